// ===== sv/rmfs_pkg.sv =====
// Shared types and constants for the random mode field synthesizer.
// No dependencies; every other file imports this package.
package rmfs_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ANGLE_BITS  = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SIDE_W      = 17;

  localparam logic [31:0] LCG_MUL    = 32'd1103515245;
  localparam logic [31:0] LCG_ADD    = 32'd12345;
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;
  localparam logic [16:0] POLY_A     = 17'd102944;
  localparam logic [15:0] POLY_B     = 16'd42048;
  localparam logic [12:0] POLY_C     = 13'd4640;

  typedef enum logic [1:0] {
    ACT_RESEED   = 2'd0,
    ACT_GENERATE = 2'd1,
    ACT_EVALUATE = 2'd2,
    ACT_NOP      = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_MODE_COUNT = 2'd0,
    REG_K_MIN      = 2'd1,
    REG_K_MAX      = 2'd2,
    REG_FIELD_AMP  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic                  vld;
    logic [SIDE_W-1:0]     side;
    logic [ANGLE_BITS-1:0] ang;
  } sin_req_t;

  typedef struct packed {
    logic               vld;
    logic [SIDE_W-1:0]  side;
    logic signed [17:0] val;
  } sin_rsp_t;

endpackage

// ===== sv/random_mode_field_synthesizer.sv =====
// Top level of the random mode field synthesizer.
// Depends on rmfs_pkg, rmfs_sine and rmfs_sqrt.
//
// Usage. A command word is taken on a rising edge where start is high and
// busy is low. in_action selects reseed (loads in_seed into the generator),
// generate (rebuilds the mode table) or evaluate (sums the modes at point
// in_pos_x/y/z). Every command yields exactly one result word: out_strobe
// is high for one cycle with out_field_value and out_is_value. Only an
// evaluate word carries a value; the others return zero with is_value low.
// The receiver cannot stall; results are simply presented for one cycle.
// Reseed and the unused code answer in the cycle after acceptance.
// Evaluate streams one mode per cycle out of the table memory through a
// multiply pipeline and the sine pipeline. Generate first works out the
// amplitude root and divide, then builds each mode in turn, using the
// 17-step square root for the polar sine. Configuration writes on cfg_we
// take effect at once; the user must make them while the block is idle,
// which the block itself does not enforce. Reset clears the generator to
// zero, restores the register defaults and leaves the table contents
// undefined until a generate command writes them.
module random_mode_field_synthesizer
  import rmfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [31:0]        in_seed,
  input  logic signed [20:0] in_pos_x,
  input  logic signed [20:0] in_pos_y,
  input  logic signed [20:0] in_pos_z,
  output logic               out_strobe,
  output logic signed [23:0] out_field_value,
  output logic               out_is_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int MC_W  = 7;
  localparam int CMP_W = (CNT_W > MC_W) ? CNT_W : MC_W;

  typedef enum logic [3:0] {
    S_IDLE, S_AMP_SQ, S_AMP_DIV, S_DRAW, S_PREP, S_KMAG, S_SQRT,
    S_RADIAL, S_SINE_B, S_WAIT, S_WRITE, S_EVAL, S_DRAIN
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [6:0]  mode_count_r;
  logic [14:0] k_min_r, k_max_r;
  logic [15:0] field_amp_r;

  // Mode table memories.
  logic [47:0]              wav_mem [TABLE_DEPTH];
  logic [15+ANGLE_BITS:0]   ap_mem  [TABLE_DEPTH];
  logic [47:0]              wav_q_r;
  logic [15+ANGLE_BITS:0]   ap_q_r;
  logic                     mem_we;

  logic [31:0]        rng_r, s1_r, s2_r, s3_r, s4_r;
  logic [1:0]         draw_r;
  logic [CNT_W-1:0]   n_r, idx_r, acc_cnt_r;
  logic [CNT_W-1:0]   n_act;
  logic               sq_start_r;
  logic [33:0]        sq_rad_r;
  logic               sq_done;
  logic [16:0]        sq_root;
  logic [11:0]        divisor_r, rem_r;
  logic [23:0]        quo_r;
  logic [4:0]         div_cnt_r;
  logic [15:0]        amp_r;
  logic signed [17:0] costh_r;
  logic signed [33:0] kprod_r;
  logic [14:0]        kmag_r;
  logic [16:0]        sinth_r;
  logic [15:0]        radial_r;
  logic [15:0]        kx_r, ky_r, kz_r;

  // Evaluate pipeline.
  logic signed [20:0] pos_x_r, pos_y_r, pos_z_r;
  logic               v1_r, v2_r, v3_r, v4_r, pv_r;
  logic signed [36:0] px_r, py_r, pz_r;
  logic signed [38:0] d_r;
  logic [15:0]        amp2_r, amp3_r, amp4_r;
  logic [ANGLE_BITS-1:0] ph2_r, ph3_r, ph4_r;
  logic [57:0]        lo_r;
  logic [27:0]        hi_r;
  logic signed [34:0] prod_r;
  logic signed [40:0] acc_r;

  sin_req_t sreq;
  sin_rsp_t srsp;

  // Combinational helpers.
  logic signed [17:0] costh;
  logic signed [35:0] csq;
  logic signed [16:0] kdiff;
  logic [12:0]        div_shift;
  logic [55:0]        d56;
  logic [57:0]        lo_m, hi_m;
  logic [55:0]        turn_sum;
  logic [ANGLE_BITS-1:0] az, eval_ang;
  logic signed [33:0] kz_m;
  logic [31:0]        rad_m;
  logic signed [34:0] kxy_m;
  logic signed [24:0] v_out;
  logic [CMP_W-1:0]   mc_ext;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    mc_ext    = CMP_W'(mode_count_r);
    n_act     = (mc_ext > CMP_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(mode_count_r);
    costh     = $signed({1'b0, s1_r[31:15]}) - 18'sd65536;
    csq       = costh * costh;
    kdiff     = $signed({2'b0, k_max_r}) - $signed({2'b0, k_min_r});
    div_shift = {rem_r, quo_r[23]};
    d56       = 56'(d_r);
    lo_m      = d56[27:0] * INV_TWO_PI;
    hi_m      = d56[55:28] * INV_TWO_PI;
    turn_sum  = lo_r[55:0] + {hi_r, 28'b0};
    eval_ang  = turn_sum[55:56-ANGLE_BITS] + ph4_r;
    az        = s2_r[31:32-ANGLE_BITS];
    kz_m      = $signed({1'b0, kmag_r}) * costh_r;
    rad_m     = kmag_r * sinth_r;
    kxy_m     = $signed({1'b0, radial_r}) * srsp.val;
    v_out     = acc_r[40:16];
    mem_we    = (state_r == S_WRITE);
  end

  // The sine pipeline is shared: generate feeds it the cosine and sine of
  // the azimuth in S_RADIAL and S_SINE_B, evaluate feeds it one mode angle per cycle.
  always_comb begin
    sreq.vld  = 1'b0;
    sreq.side = '0;
    sreq.ang  = eval_ang;
    if (state_r == S_RADIAL) begin
      sreq.vld = 1'b1;
      sreq.ang = az + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
    end else if (state_r == S_SINE_B) begin
      sreq.vld  = 1'b1;
      sreq.side = SIDE_W'(1);
      sreq.ang  = az;
    end else if (v4_r) begin
      sreq.vld  = 1'b1;
      sreq.side = {1'b0, amp4_r};
    end
  end

  rmfs_sine u_sine (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sreq),
    .rsp   (srsp)
  );

  rmfs_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start_r),
    .rad   (sq_rad_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  // Table memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wav_mem[idx_r[IDX_W-1:0]] <= {kx_r, ky_r, kz_r};
      ap_mem[idx_r[IDX_W-1:0]]  <= {amp_r, s4_r[31:32-ANGLE_BITS]};
    end
    wav_q_r <= wav_mem[idx_r[IDX_W-1:0]];
    ap_q_r  <= ap_mem[idx_r[IDX_W-1:0]];
  end

  // Evaluate datapath stages behind the memory read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      v1_r <= (state_r == S_EVAL);
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      pv_r <= srsp.vld && (state_r == S_EVAL || state_r == S_DRAIN);
    end
    px_r   <= $signed(wav_q_r[47:32]) * pos_x_r;
    py_r   <= $signed(wav_q_r[31:16]) * pos_y_r;
    pz_r   <= $signed(wav_q_r[15:0]) * pos_z_r;
    amp2_r <= ap_q_r[15+ANGLE_BITS:ANGLE_BITS];
    ph2_r  <= ap_q_r[ANGLE_BITS-1:0];
    d_r    <= 39'(px_r) + 39'(py_r) + 39'(pz_r);
    amp3_r <= amp2_r;
    ph3_r  <= ph2_r;
    lo_r   <= lo_m;
    hi_r   <= hi_m[27:0];
    amp4_r <= amp3_r;
    ph4_r  <= ph3_r;
    prod_r <= $signed({1'b0, srsp.side[15:0]}) * srsp.val;
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_count_r <= 7'd32;
      k_min_r      <= 15'd1229;
      k_max_r      <= 15'd6144;
      field_amp_r  <= 16'd3277;
      rng_r        <= '0;
      out_strobe   <= 1'b0;
      sq_start_r   <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      sq_start_r <= 1'b0;
      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          REG_MODE_COUNT: mode_count_r <= cfg_data[6:0];
          REG_K_MIN:      k_min_r      <= cfg_data[14:0];
          REG_K_MAX:      k_max_r      <= cfg_data[14:0];
          REG_FIELD_AMP:  field_amp_r  <= cfg_data;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            n_r     <= n_act;
            idx_r   <= '0;
            acc_r   <= '0;
            acc_cnt_r <= '0;
            pos_x_r <= in_pos_x;
            pos_y_r <= in_pos_y;
            pos_z_r <= in_pos_z;
            out_field_value <= '0;
            out_is_value    <= 1'b0;
            unique case (action_t'(in_action))
              ACT_RESEED: begin
                rng_r      <= in_seed;
                out_strobe <= 1'b1;
              end
              ACT_GENERATE: begin
                if (n_act == '0) begin
                  out_strobe <= 1'b1;
                end else begin
                  sq_rad_r   <= 34'(n_act) << 16;
                  sq_start_r <= 1'b1;
                  state_r    <= S_AMP_SQ;
                end
              end
              ACT_EVALUATE: begin
                if (n_act == '0) begin
                  out_strobe   <= 1'b1;
                  out_is_value <= 1'b1;
                end else begin
                  state_r <= S_EVAL;
                end
              end
              ACT_NOP: out_strobe <= 1'b1;
            endcase
          end
        end
        S_AMP_SQ: begin
          if (sq_done) begin
            divisor_r <= sq_root[11:0];
            rem_r     <= '0;
            quo_r     <= {field_amp_r, 8'b0};
            div_cnt_r <= 5'd24;
            state_r   <= S_AMP_DIV;
          end
        end
        S_AMP_DIV: begin
          // Restoring division: one quotient bit per cycle.
          if (div_shift >= {1'b0, divisor_r}) begin
            rem_r <= 12'(div_shift - {1'b0, divisor_r});
            quo_r <= {quo_r[22:0], 1'b1};
          end else begin
            rem_r <= div_shift[11:0];
            quo_r <= {quo_r[22:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r - 5'd1;
          if (div_cnt_r == 5'd1) begin
            state_r <= S_DRAW;
            draw_r  <= '0;
          end
        end
        S_DRAW: begin
          amp_r <= quo_r[15:0];
          rng_r <= rng_r * LCG_MUL + LCG_ADD;
          unique case (draw_r)
            2'd0: s1_r <= rng_r * LCG_MUL + LCG_ADD;
            2'd1: s2_r <= rng_r * LCG_MUL + LCG_ADD;
            2'd2: s3_r <= rng_r * LCG_MUL + LCG_ADD;
            2'd3: s4_r <= rng_r * LCG_MUL + LCG_ADD;
          endcase
          draw_r <= draw_r + 2'd1;
          if (draw_r == 2'd3) state_r <= S_PREP;
        end
        S_PREP: begin
          costh_r  <= costh;
          sq_rad_r <= 34'h1_0000_0000 - csq[33:0];
          kprod_r  <= kdiff * $signed({1'b0, s3_r[31:16]});
          state_r  <= S_KMAG;
        end
        S_KMAG: begin
          kmag_r     <= 15'(kprod_r[33:16] + $signed({3'b0, k_min_r}));
          sq_start_r <= 1'b1;
          state_r    <= S_SQRT;
        end
        S_SQRT: begin
          kz_r <= kz_m[31:16];
          if (sq_done) begin
            sinth_r <= sq_root;
            state_r <= S_RADIAL;
          end
        end
        S_RADIAL: begin
          radial_r <= rad_m[31:16];
          state_r  <= S_SINE_B;
        end
        S_SINE_B: state_r <= S_WAIT;
        S_WAIT: begin
          if (srsp.vld) begin
            if (srsp.side[0]) begin
              ky_r    <= kxy_m[31:16];
              state_r <= S_WRITE;
            end else begin
              kx_r <= kxy_m[31:16];
            end
          end
        end
        S_WRITE: begin
          idx_r  <= idx_r + 1'b1;
          draw_r <= '0;
          if (idx_r + 1'b1 == n_r) begin
            out_strobe <= 1'b1;
            state_r    <= S_IDLE;
          end else begin
            state_r <= S_DRAW;
          end
        end
        S_EVAL: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r + 1'b1 == n_r) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (acc_cnt_r == n_r) begin
            out_strobe   <= 1'b1;
            out_is_value <= 1'b1;
            if (v_out > 25'sd8388607) out_field_value <= 24'sh7FFFFF;
            else if (v_out < -25'sd8388608) out_field_value <= 24'sh800000;
            else out_field_value <= v_out[23:0];
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (pv_r) begin
        acc_r     <= acc_r + 41'(prod_r);
        acc_cnt_r <= acc_cnt_r + 1'b1;
      end
    end
  end

endmodule

// ===== sv/rmfs_sine.sv =====
// Five-stage pipelined quarter-wave polynomial sine in Q16.
// Depends on rmfs_pkg for the request and response words.
module rmfs_sine
  import rmfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  sin_req_t req,
  output sin_rsp_t rsp
);

  logic [3:0]        v_r;
  logic [SIDE_W-1:0] side_r [4];
  logic [1:0]        q1_r, q2_r, q3_r, q4_r;
  logic [16:0]       t1_r, t2t_r, t3t_r, t4t_r;
  logic [16:0]       t2_r, t3sq_r;
  logic [15:0]       p1_r;
  logic [16:0]       p2_r;

  logic [ANGLE_BITS+5:0] tw;
  logic [15:0]           t16;
  logic [16:0]           t1;
  logic [33:0]           m1;
  logic [29:0]           m2;
  logic [32:0]           m3;
  logic [33:0]           m4;
  logic [16:0]           mag;

  always_comb begin
    tw  = {req.ang[ANGLE_BITS-3:0], 8'b0} >> (ANGLE_BITS - 10);
    t16 = tw[15:0];
    t1  = req.ang[ANGLE_BITS-2] ? (17'd65536 - {1'b0, t16}) : {1'b0, t16};
    m1  = t1_r * t1_r;
    m2  = t2_r * POLY_C;
    m3  = t3sq_r * p1_r;
    m4  = t4t_r * p2_r;
    mag = m4[32:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      rsp.vld <= 1'b0;
    end else begin
      v_r     <= {v_r[2:0], req.vld};
      rsp.vld <= v_r[3];
    end
    side_r[0] <= req.side;
    side_r[1] <= side_r[0];
    side_r[2] <= side_r[1];
    side_r[3] <= side_r[2];
    rsp.side  <= side_r[3];
    q1_r  <= req.ang[ANGLE_BITS-1:ANGLE_BITS-2];
    t1_r  <= t1;
    q2_r  <= q1_r;
    t2t_r <= t1_r;
    t2_r  <= m1[32:16];
    q3_r  <= q2_r;
    t3t_r <= t2t_r;
    t3sq_r <= t2_r;
    p1_r  <= POLY_B - {3'b0, m2[28:16]};
    q4_r  <= q3_r;
    t4t_r <= t3t_r;
    p2_r  <= POLY_A - {1'b0, m3[31:16]};
    rsp.val <= q4_r[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

// ===== sv/rmfs_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on rmfs_pkg only for the common import convention.
module rmfs_sqrt
  import rmfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [33:0] rad,
  output logic        done,
  output logic [16:0] root
);

  logic [34:0] v_r, r_r, bit_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic [34:0] trial;

  assign trial = r_r + bit_r;
  assign root  = r_r[16:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      done  <= 1'b0;
      cnt_r <= 5'd17;
    end else if (run_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        run_r <= 1'b0;
        done  <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
    if (start) begin
      v_r   <= {1'b0, rad};
      r_r   <= '0;
      bit_r <= 35'h1_0000_0000;
    end else if (run_r) begin
      if (v_r >= trial) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

// ===== bench/tb_random_mode_field_synthesizer.sv =====
// Testbench for random_mode_field_synthesizer: directed and random command words
// are checked against a predictor of the generator, the mode table and the field sum.
// Depends on rmfs_pkg and the synthesizer RTL only.
`timescale 1ns / 100ps

module tb_random_mode_field_synthesizer;
  import rmfs_pkg::*;

  typedef struct {
    action_t            act;
    logic [31:0]        seed;
    logic signed [20:0] px;
    logic signed [20:0] py;
    logic signed [20:0] pz;
  } command_t;

  typedef struct {
    logic signed [23:0] field_value;
    logic               is_value;
  } field_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_action = '0;
  logic [31:0]        in_seed = '0;
  logic signed [20:0] in_pos_x = '0;
  logic signed [20:0] in_pos_y = '0;
  logic signed [20:0] in_pos_z = '0;
  logic               out_strobe;
  logic signed [23:0] out_field_value;
  logic               out_is_value;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  random_mode_field_synthesizer dut (
    .clk, .rst_n, .start, .busy,
    .in_action, .in_seed, .in_pos_x, .in_pos_y, .in_pos_z,
    .out_strobe, .out_field_value, .out_is_value,
    .cfg_we, .cfg_index, .cfg_data
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copies of the configuration registers and of the block's state.
  logic [6:0]  cnt_reg = 7'd32;
  logic [14:0] kmin_reg = 15'd1229;
  logic [14:0] kmax_reg = 15'd6144;
  logic [15:0] famp_reg = 16'd3277;
  logic [31:0] lcg = '0;
  longint      mode_kx [TABLE_DEPTH];
  longint      mode_ky [TABLE_DEPTH];
  longint      mode_kz [TABLE_DEPTH];
  longint      mode_amp [TABLE_DEPTH];
  logic [ANGLE_BITS-1:0] mode_phase [TABLE_DEPTH];

  command_t      command_queue[$];
  field_result_t pending_results[$];
  command_t      cur_cmd;
  int            gap_left = 0;
  bit            gaps_on = 1'b1;
  int            errors = 0;

  function automatic int active_modes(logic [6:0] c);
    return (c > TABLE_DEPTH) ? TABLE_DEPTH : int'(c);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Quarter-wave polynomial sine, Q16 result.
  function automatic longint sine_q16(logic [ANGLE_BITS-1:0] a);
    logic [1:0]      quad;
    longint unsigned t, t2, p;
    quad = a[ANGLE_BITS-1 -: 2];
    t = (longint'(a[ANGLE_BITS-3:0]) << 8) >> (ANGLE_BITS - 10);
    if (quad[0]) t = 65536 - t;
    t2 = (t * t) >> 16;
    p = longint'(POLY_B) - ((t2 * longint'(POLY_C)) >> 16);
    p = longint'(POLY_A) - ((t2 * p) >> 16);
    p = (t * p) >> 16;
    return quad[1] ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [31:0] lcg_draw();
    lcg = lcg * LCG_MUL + LCG_ADD;
    return lcg;
  endfunction

  task automatic build_modes();
    int          n;
    longint      amp, costh, sinth, kmag, radial;
    logic [31:0] s1, s2, s3, s4;
    logic [ANGLE_BITS-1:0] az;
    n = active_modes(cnt_reg);
    if (n == 0) return;
    amp = (longint'(famp_reg) << 8) / longint'(isqrt(longint'(n) << 16));
    for (int i = 0; i < n; i++) begin
      s1 = lcg_draw();
      s2 = lcg_draw();
      s3 = lcg_draw();
      s4 = lcg_draw();
      costh = longint'(s1 >> 15) - 65536;
      sinth = longint'(isqrt(64'h1_0000_0000 - costh * costh));
      az = s2[31 -: ANGLE_BITS];
      kmag = longint'(kmin_reg) +
             (((longint'(kmax_reg) - longint'(kmin_reg)) * longint'(s3 >> 16)) >>> 16);
      radial = (kmag * sinth) >>> 16;
      mode_kx[i] = (radial * sine_q16(az + ANGLE_BITS'(1 << (ANGLE_BITS - 2)))) >>> 16;
      mode_ky[i] = (radial * sine_q16(az)) >>> 16;
      mode_kz[i] = (kmag * costh) >>> 16;
      mode_amp[i] = amp;
      mode_phase[i] = s4[31 -: ANGLE_BITS];
    end
  endtask

  function automatic logic signed [23:0] field_at(longint x, longint y, longint z);
    longint          acc, d;
    longint unsigned turns;
    logic [ANGLE_BITS-1:0] ang;
    acc = 0;
    for (int i = 0; i < active_modes(cnt_reg); i++) begin
      d = mode_kx[i] * x + mode_ky[i] * y + mode_kz[i] * z;
      turns = (longint'(d) * 64'd683565276) >> (56 - ANGLE_BITS);
      ang = turns[ANGLE_BITS-1:0] + mode_phase[i];
      acc += mode_amp[i] * sine_q16(ang);
    end
    acc = acc >>> 16;
    if (acc > 8388607) acc = 8388607;
    if (acc < -8388608) acc = -8388608;
    return acc[23:0];
  endfunction

  // Updates the shadow state for one accepted word and queues the result it owes.
  task automatic apply_command(command_t c);
    field_result_t r;
    r.field_value = '0;
    r.is_value = 1'b0;
    case (c.act)
      ACT_RESEED:   lcg = c.seed;
      ACT_GENERATE: build_modes();
      ACT_EVALUATE: begin
        r.field_value = field_at(c.px, c.py, c.pz);
        r.is_value = 1'b1;
      end
      default: ;
    endcase
    pending_results.push_back(r);
  endtask

  // Driver: a word is taken at an edge where start is high and busy is low.
  // After each word it draws a random gap before the next one, or none when gaps are off.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_command(cur_cmd);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (command_queue.size() > 0) begin
          cur_cmd = command_queue.pop_front();
          in_action <= cur_cmd.act;
          in_seed <= cur_cmd.seed;
          in_pos_x <= cur_cmd.px;
          in_pos_y <= cur_cmd.py;
          in_pos_z <= cur_cmd.pz;
          start <= 1'b1;
          gap_left <= gaps_on ? $urandom_range(0, 5) : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result word is matched against the oldest prediction.
  always @(posedge clk) begin
    field_result_t e;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result word with no prediction waiting");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_field_value !== e.field_value) begin
          $error("field_value expected %0d actual %0d", e.field_value, out_field_value);
          errors++;
        end
        if (out_is_value !== e.is_value) begin
          $error("is_value expected %0d actual %0d", e.is_value, out_is_value);
          errors++;
        end
      end
    end
  end

  // Stimulus side bookkeeping: how many table entries hold generated modes.
  // An evaluate that would read past them is turned into a generate.
  int written = 0;

  task automatic push_cmd(action_t act, logic [31:0] seed = $urandom(),
                          int x = $urandom(), int y = $urandom(), int z = $urandom());
    command_t c;
    int       n;
    n = active_modes(cnt_reg);
    if (act == ACT_EVALUATE && n > written) act = ACT_GENERATE;
    if (act == ACT_GENERATE && n > written) written = n;
    c.act = act;
    c.seed = seed;
    c.px = x[20:0];
    c.py = y[20:0];
    c.pz = z[20:0];
    command_queue.push_back(c);
  endtask

  // Waits until every queued word has gone in and every result has come back.
  task automatic drain();
    do @(negedge clk);
    while (command_queue.size() != 0 || start || pending_results.size() != 0 || busy);
  endtask

  // Register writes happen only here, with the block idle.
  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MODE_COUNT: cnt_reg = val[6:0];
      REG_K_MIN:      kmin_reg = val[14:0];
      REG_K_MAX:      kmax_reg = val[14:0];
      default:        famp_reg = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_cmd();
    int pick, x, y, z;
    pick = $urandom_range(0, 99);
    x = $urandom();
    y = $urandom();
    z = $urandom();
    // Corners of the coordinate range for x and y now and then, and z at zero.
    if ($urandom_range(0, 9) == 0) x = $urandom_range(0, 1) ? -1048576 : 1048575;
    if ($urandom_range(0, 9) == 0) y = $urandom_range(0, 1) ? -1048576 : 1048575;
    if ($urandom_range(0, 9) == 0) z = 0;
    if (pick < 5)       push_cmd(ACT_RESEED);
    else if (pick < 11) push_cmd(ACT_GENERATE);
    else if (pick < 14) push_cmd(ACT_NOP);
    else                push_cmd(ACT_EVALUATE, $urandom(), x, y, z);
  endtask

  initial begin
    int cnt;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings: no operation, seeds at both ends,
    // evaluation at the origin and at the corners of the coordinate range.
    push_cmd(ACT_NOP);
    push_cmd(ACT_RESEED, 32'h0);
    push_cmd(ACT_GENERATE);
    push_cmd(ACT_EVALUATE, 0, 0, 0, 0);
    push_cmd(ACT_EVALUATE, 0, 1048575, 1048575, 1048575);
    push_cmd(ACT_EVALUATE, 0, -1048576, -1048576, -1048576);
    push_cmd(ACT_EVALUATE, 0, -1048576, 1048575, 4096);
    push_cmd(ACT_RESEED, 32'hFFFF_FFFF);
    push_cmd(ACT_GENERATE);
    push_cmd(ACT_EVALUATE, 0, 4096, -4096, 1);
    drain();

    // A zero mode count builds nothing and sums to zero.
    write_reg(REG_MODE_COUNT, 16'd0);
    push_cmd(ACT_GENERATE);
    push_cmd(ACT_EVALUATE, 0, 12345, -999, 77);
    drain();

    // A count above the table acts as the full table; magnitudes run downward
    // when k_max is below k_min.
    write_reg(REG_MODE_COUNT, 16'd127);
    write_reg(REG_K_MIN, 16'd32767);
    write_reg(REG_K_MAX, 16'd0);
    push_cmd(ACT_GENERATE);
    push_cmd(ACT_EVALUATE, 0, 1048575, -1048576, 1048575);
    push_cmd(ACT_EVALUATE);
    drain();

    // A single mode at full amplitude, then zero amplitude over the widest k span.
    write_reg(REG_MODE_COUNT, 16'd1);
    write_reg(REG_FIELD_AMP, 16'hFFFF);
    push_cmd(ACT_GENERATE);
    push_cmd(ACT_EVALUATE, 0, 1048575, 1048575, -1048576);
    drain();
    write_reg(REG_MODE_COUNT, 16'd64);
    write_reg(REG_K_MIN, 16'd0);
    write_reg(REG_K_MAX, 16'd32767);
    write_reg(REG_FIELD_AMP, 16'd0);
    push_cmd(ACT_GENERATE);
    push_cmd(ACT_EVALUATE);
    drain();

    // Random phases, each with its own settings; the drain between phases
    // also makes the sender wait for every outstanding result.
    for (int ph = 0; ph < 8; ph++) begin
      gaps_on = (ph % 3 != 1);
      case (ph)
        0: cnt = 64;
        1: cnt = 1;
        2: cnt = 127;
        default: cnt = $urandom_range(0, 127);
      endcase
      write_reg(REG_MODE_COUNT, 16'(cnt));
      write_reg(REG_K_MIN, (ph == 1) ? 16'd32767 : 16'($urandom_range(0, 32767)));
      write_reg(REG_K_MAX, (ph == 2) ? 16'd0 : 16'($urandom_range(0, 32767)));
      write_reg(REG_FIELD_AMP, (ph == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
      push_cmd(ACT_RESEED);
      push_cmd(ACT_GENERATE);
      for (int i = 0; i < 170; i++) random_cmd();
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== random_mode_field_synthesizer.f =====
sv/rmfs_pkg.sv
sv/rmfs_sine.sv
sv/rmfs_sqrt.sv
sv/random_mode_field_synthesizer.sv
bench/tb_random_mode_field_synthesizer.sv
